// ===== rtl/bresenham_line_stepper_top_macros.svh =====
// assertion macros for the line stepper checker
// clocked on clock, disabled while reset is high
`ifndef BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH

// same-cycle implication
`define BLS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("line stepper check failed");

// next-cycle implication
`define BLS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("line stepper check failed");

`endif

// ===== rtl/bls_pkg.sv =====
// shared codes for the line stepper: command values, octant group codes, control struct
// no dependencies
`default_nettype none

package bls_pkg;

   // command field
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // octant groups, the axis that is folded onto +major
   localparam logic [1:0] GRP_POS_X = 2'd0;
   localparam logic [1:0] GRP_NEG_X = 2'd1;
   localparam logic [1:0] GRP_POS_Y = 2'd2;
   localparam logic [1:0] GRP_NEG_Y = 2'd3;

   // what the front register hands the stepper this cycle
   typedef struct packed {
      logic load;
      logic step;
   } bls_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/bls_setup.sv =====
// endpoint fold for a load: octant group, major/minor axes and error term seeds
// depends on bls_pkg
`default_nettype none

module bls_setup #(
   parameter int COORD_WIDTH = 15
) (
   input  wire logic signed [COORD_WIDTH-1:0] start_x,
   input  wire logic signed [COORD_WIDTH-1:0] start_y,
   input  wire logic signed [COORD_WIDTH-1:0] end_x,
   input  wire logic signed [COORD_WIDTH-1:0] end_y,
   output logic        [1:0]               group,
   output logic signed [COORD_WIDTH:0]     major_pos,
   output logic signed [COORD_WIDTH:0]     major_end,
   output logic signed [COORD_WIDTH-1:0]   minor_pos,
   output logic signed [1:0]               minor_dir,
   output logic        [COORD_WIDTH:0]     twice_rise,
   output logic        [COORD_WIDTH:0]     twice_run,
   output logic signed [COORD_WIDTH+3:0]   error_init
);
   import bls_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;

   logic signed [DW-1:0] sx, sy, ex, ey;
   logic signed [DW-1:0] xp, xn, yp, yn;
   logic signed [DW-1:0] b0, b1, minor_diff, minor_abs, run_len;
   logic                 pick_xp, pick_xn, pick_yp;

   assign sx = {start_x[W-1], start_x};
   assign sy = {start_y[W-1], start_y};
   assign ex = {end_x[W-1], end_x};
   assign ey = {end_y[W-1], end_y};

   assign xp = ex - sx;
   assign xn = sx - ex;
   assign yp = ey - sy;
   assign yn = sy - ey;

   // largest of the four, ties in order +x, -x, +y, -y
   assign pick_xp = (xp >= xn) && (xp >= yp) && (xp >= yn);
   assign pick_xn = (xn >= yp) && (xn >= yn);
   assign pick_yp = (yp >= yn);

   always_comb begin
      if (pick_xp) begin
         group     = GRP_POS_X;
         major_pos = sx;
         major_end = ex;
         b0        = sy;
         b1        = ey;
      end else if (pick_xn) begin
         group     = GRP_NEG_X;
         major_pos = -sx;
         major_end = -ex;
         b0        = sy;
         b1        = ey;
      end else if (pick_yp) begin
         group     = GRP_POS_Y;
         major_pos = sy;
         major_end = ey;
         b0        = sx;
         b1        = ex;
      end else begin
         group     = GRP_NEG_Y;
         major_pos = -sy;
         major_end = -ey;
         b0        = sx;
         b1        = ex;
      end
   end

   assign minor_diff = b1 - b0;
   assign minor_abs  = minor_diff[DW-1] ? -minor_diff : minor_diff;
   // fold makes this the non-negative maximum
   assign run_len    = major_end - major_pos;

   assign minor_pos  = b0[W-1:0];
   assign minor_dir  = minor_diff[DW-1] ? 2'sb11 :
                       ((minor_diff != '0) ? 2'sb01 : 2'sb00);
   assign twice_rise = {minor_abs[W-1:0], 1'b0};
   assign twice_run  = {run_len[W-1:0], 1'b0};
   assign error_init = $signed({3'b000, minor_abs[W-1:0], 1'b0})
                     - $signed({4'b0000, run_len[W-1:0]});

endmodule

`default_nettype wire

// ===== rtl/bls_stepper.sv =====
// line state registers and the per-step error update, point unfold to original axes
// depends on bls_pkg
`default_nettype none

module bls_stepper #(
   parameter int COORD_WIDTH = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bls_pkg::bls_ctl_type          ctl,
   input  wire logic        [1:0]             load_group,
   input  wire logic signed [COORD_WIDTH:0]   load_major_pos,
   input  wire logic signed [COORD_WIDTH:0]   load_major_end,
   input  wire logic signed [COORD_WIDTH-1:0] load_minor_pos,
   input  wire logic signed [1:0]             load_minor_dir,
   input  wire logic        [COORD_WIDTH:0]   load_twice_rise,
   input  wire logic        [COORD_WIDTH:0]   load_twice_run,
   input  wire logic signed [COORD_WIDTH+3:0] load_error,
   output logic                               emit,
   output logic signed [COORD_WIDTH-1:0]      point_x,
   output logic signed [COORD_WIDTH-1:0]      point_y,
   output logic                               last_point
);
   import bls_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 1;
   localparam int EW = COORD_WIDTH + 4;

   logic                 active_ff, active_in;
   logic [1:0]           group_ff, group_in;
   logic signed [DW-1:0] major_ff, major_in;
   logic signed [DW-1:0] major_end_ff, major_end_in;
   logic signed [W-1:0]  minor_ff, minor_in;
   logic signed [1:0]    dir_ff, dir_in;
   logic [DW-1:0]        rise_ff, rise_in;
   logic [DW-1:0]        run_ff, run_in;
   logic signed [EW-1:0] error_ff, error_in;

   logic signed [EW-1:0] error_sum;
   logic signed [DW-1:0] major_neg;
   logic                 at_end;

   assign at_end    = (major_ff >= major_end_ff);
   assign major_neg = -major_ff;
   assign error_sum = error_ff + $signed({3'b000, rise_ff});
   assign emit      = ctl.step && active_ff;

   always_comb begin
      case (group_ff)
         GRP_POS_X: begin
            point_x = major_ff[W-1:0];
            point_y = minor_ff;
         end
         GRP_NEG_X: begin
            point_x = major_neg[W-1:0];
            point_y = minor_ff;
         end
         GRP_POS_Y: begin
            point_x = minor_ff;
            point_y = major_ff[W-1:0];
         end
         default: begin
            point_x = minor_ff;
            point_y = major_neg[W-1:0];
         end
      endcase
   end

   assign last_point = at_end;

   always_comb begin
      active_in    = active_ff;
      group_in     = group_ff;
      major_in     = major_ff;
      major_end_in = major_end_ff;
      minor_in     = minor_ff;
      dir_in       = dir_ff;
      rise_in      = rise_ff;
      run_in       = run_ff;
      error_in     = error_ff;
      if (ctl.load) begin
         active_in    = 1'b1;
         group_in     = load_group;
         major_in     = load_major_pos;
         major_end_in = load_major_end;
         minor_in     = load_minor_pos;
         dir_in       = load_minor_dir;
         rise_in      = load_twice_rise;
         run_in       = load_twice_run;
         error_in     = load_error;
      end else if (emit) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            major_in = major_ff + DW'(1);
            if (error_sum > 0) begin
               error_in = error_sum - $signed({3'b000, run_ff});
               minor_in = minor_ff + {{(W-2){dir_ff[1]}}, dir_ff};
            end else begin
               error_in = error_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         group_ff     <= GRP_POS_X;
         major_ff     <= '0;
         major_end_ff <= '0;
         minor_ff     <= '0;
         dir_ff       <= '0;
         rise_ff      <= '0;
         run_ff       <= '0;
         error_ff     <= '0;
      end else begin
         active_ff    <= active_in;
         group_ff     <= group_in;
         major_ff     <= major_in;
         major_end_ff <= major_end_in;
         minor_ff     <= minor_in;
         dir_ff       <= dir_in;
         rise_ff      <= rise_in;
         run_ff       <= run_in;
         error_ff     <= error_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_stepper_top.sv =====
// top level of the line stepper: request register, setup fold, stepper and result register
// depends on bls_pkg, bls_setup and bls_stepper
//
// usage
//   req_ channel carries one command per beat: a load (endpoints in start/end x/y)
//   or a step. a load returns nothing and replaces any line in progress. each step
//   while a line is active returns one rsp_ beat with the next point and
//   rsp_last_point set on the final one, after which the line is closed; a step
//   with no active line returns nothing
//   path: a step accepted into the request register is worked by the stepper once
//   it advances, and its point is registered in the result register
//   throughput: one command per cycle while no stalled result beat holds it, with the
//   error update (one add, compare and subtract) between request and result registers
//   stall: while rsp_valid is high and rsp_ready low the result register holds
//   and the request register holds its beat; req_ready stays high as long as the
//   request register is empty, so one extra beat is taken during a stall
//   reset: clears both valid flags and the line state, no line is active
`default_nettype none

module bresenham_line_stepper_top #(
   parameter int COORD_WIDTH = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_command,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_y,
   output logic                               rsp_last_point
);
   import bls_pkg::*;

   localparam int W = COORD_WIDTH;

   // request register
   logic                req_full_ff, req_full_in;
   logic                cmd_ff;
   logic signed [W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] point_x_ff, point_y_ff;
   logic                last_ff;

   logic                req_beat;
   logic                advance;
   bls_ctl_type         ctl;

   // fold outputs
   logic [1:0]           fold_group;
   logic signed [W:0]    fold_major_pos, fold_major_end;
   logic signed [W-1:0]  fold_minor_pos;
   logic signed [1:0]    fold_minor_dir;
   logic [W:0]           fold_twice_rise, fold_twice_run;
   logic signed [W+3:0]  fold_error;

   // stepper outputs
   logic                 step_emit;
   logic signed [W-1:0]  step_point_x, step_point_y;
   logic                 step_last;

   // held command moves on once the result slot is free or being drained
   assign advance   = req_full_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_full_ff || advance;
   assign req_beat  = req_valid && req_ready;

   assign ctl.load = advance && (cmd_ff == CMD_LOAD);
   assign ctl.step = advance && (cmd_ff == CMD_STEP);

   bls_setup #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_setup (
      .start_x    (start_x_ff),
      .start_y    (start_y_ff),
      .end_x      (end_x_ff),
      .end_y      (end_y_ff),
      .group      (fold_group),
      .major_pos  (fold_major_pos),
      .major_end  (fold_major_end),
      .minor_pos  (fold_minor_pos),
      .minor_dir  (fold_minor_dir),
      .twice_rise (fold_twice_rise),
      .twice_run  (fold_twice_run),
      .error_init (fold_error)
   );

   bls_stepper #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_stepper (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .load_group      (fold_group),
      .load_major_pos  (fold_major_pos),
      .load_major_end  (fold_major_end),
      .load_minor_pos  (fold_minor_pos),
      .load_minor_dir  (fold_minor_dir),
      .load_twice_rise (fold_twice_rise),
      .load_twice_run  (fold_twice_run),
      .load_error      (fold_error),
      .emit            (step_emit),
      .point_x         (step_point_x),
      .point_y         (step_point_y),
      .last_point      (step_last)
   );

   // request register valid: filled by a beat, emptied when it advances
   assign req_full_in  = req_beat || (req_full_ff && !advance);
   // result register valid: new point, or the old one still waiting
   assign rsp_valid_in = step_emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_full_ff  <= req_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff     <= req_command;
         start_x_ff <= req_start_x;
         start_y_ff <= req_start_y;
         end_x_ff   <= req_end_x;
         end_y_ff   <= req_end_y;
      end
      if (step_emit) begin
         point_x_ff <= step_point_x;
         point_y_ff <= step_point_y;
         last_ff    <= step_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = point_x_ff;
   assign rsp_point_y    = point_y_ff;
   assign rsp_last_point = last_ff;

endmodule

`default_nettype wire

// ===== rtl/bls_checker.sv =====
// port-level checks for the line stepper, bound to the top level
// depends on bresenham_line_stepper_top_macros.svh
`default_nettype none

`include "bresenham_line_stepper_top_macros.svh"

module bls_checker #(
   parameter int COORD_WIDTH = 15
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_command,
   input wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input wire logic signed [COORD_WIDTH-1:0] req_end_y,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [COORD_WIDTH-1:0] rsp_point_x,
   input wire logic signed [COORD_WIDTH-1:0] rsp_point_y,
   input wire logic                          rsp_last_point
);

   logic [4*COORD_WIDTH:0] req_payload;
   logic [2*COORD_WIDTH:0] rsp_payload;

   assign req_payload = {req_command, req_start_x, req_start_y, req_end_x, req_end_y};
   assign rsp_payload = {rsp_point_x, rsp_point_y, rsp_last_point};

   // a waiting request beat holds
   `BLS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_payload))

   // a stalled result beat holds
   `BLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // nothing comes out right after reset
   `BLS_ASSERT_NOW(a_reset_quiet, $fell(reset), !rsp_valid)

   // a closed line needs a new load, so no beat follows the last point directly
   `BLS_ASSERT_NEXT(a_last_gap, rsp_valid && rsp_ready && rsp_last_point, !rsp_valid)

   // with the result slot free the request side never stalls
   `BLS_ASSERT_NOW(a_req_open, !rsp_valid, req_ready)

endmodule

bind bresenham_line_stepper_top bls_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_bls_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking bench for bresenham_line_stepper_top: directed table, then random lines
// with random idles on both channels; depends on bls_pkg and the line stepper rtl
module tb_top;
   import bls_pkg::*;

   localparam int CW          = 15;
   localparam int COORD_MIN   = -(1 << (CW - 1));
   localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
   localparam int ITEM_TARGET = 1750;
   localparam int STUCK_LIMIT = 2000;   // cycles with no beat on either side
   localparam int DRAIN_WAIT  = 10;     // stall margin for the quiet tail after the drain

   // how a request beat gets its expected point
   typedef enum logic [1:0] {
      CHK_PREDICT,   // whatever the line predictor says
      CHK_NOTHING,   // no point may come back
      CHK_TYPED      // the point written in the stimulus row
   } chk_kind_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 last;
   } point_type;

   typedef struct {
      logic                 cmd;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      chk_kind_type         kind;
      point_type            pt;
   } stim_row_type;

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   initial forever #5 clock = ~clock;

   // dut ports, all known from time zero
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_command = CMD_LOAD;
   logic signed [CW-1:0] req_start_x = '0;
   logic signed [CW-1:0] req_start_y = '0;
   logic signed [CW-1:0] req_end_x = '0;
   logic signed [CW-1:0] req_end_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_point_x;
   logic signed [CW-1:0] rsp_point_y;
   logic                 rsp_last_point;

   // check mode that travels with the request beat
   chk_kind_type beat_kind = CHK_PREDICT;
   point_type    beat_point = '0;

   // when set, neither side idles
   logic quiet = 1'b0;

   bresenham_line_stepper_top #(
      .COORD_WIDTH (CW)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

   // ------------------------------------------------------------------
   // line predictor: folded major/minor stepping state
   // ------------------------------------------------------------------
   bit         line_on   = 1'b0;
   logic [1:0] fold_grp  = GRP_POS_X;
   int         maj_pos   = 0;
   int         maj_end   = 0;
   int         min_pos   = 0;
   int         min_dir   = 0;
   int         err_term  = 0;
   int         rise_x2   = 0;
   int         run_x2    = 0;

   point_type    pending_points[$];   // points the dut still owes
   int           error_count = 0;
   int           items_sent = 0;
   stim_row_type plan[$];

   // one request beat through the predictor; made is set when a point comes out
   task automatic raster_step(input logic cmd,
                              input logic signed [CW-1:0] sx, sy, ex, ey,
                              output bit made, output point_type pt);
      int ax, ay, bx, by;
      int xp, xn, yp, yn, top;
      int m0, m1, n0, n1, rise, run;
      int px, py;
      bit at_end;
      made = 1'b0;
      pt = '0;
      if (cmd == CMD_LOAD) begin
         ax = sx;
         ay = sy;
         bx = ex;
         by = ey;
         xp = bx - ax;
         xn = ax - bx;
         yp = by - ay;
         yn = ay - by;
         top = xp;
         if (xn > top) top = xn;
         if (yp > top) top = yp;
         if (yn > top) top = yn;
         // ties go to +x, then -x, then +y
         if (xp == top) begin
            fold_grp = GRP_POS_X; m0 = ax;  m1 = bx;  n0 = ay; n1 = by;
         end else if (xn == top) begin
            fold_grp = GRP_NEG_X; m0 = -ax; m1 = -bx; n0 = ay; n1 = by;
         end else if (yp == top) begin
            fold_grp = GRP_POS_Y; m0 = ay;  m1 = by;  n0 = ax; n1 = bx;
         end else begin
            fold_grp = GRP_NEG_Y; m0 = -ay; m1 = -by; n0 = ax; n1 = bx;
         end
         maj_pos = m0;
         maj_end = m1;
         min_pos = n0;
         rise = (n1 > n0) ? n1 - n0 : n0 - n1;
         run = (m1 > m0) ? m1 - m0 : m0 - m1;
         min_dir = (n1 > n0) ? 1 : ((n1 < n0) ? -1 : 0);
         rise_x2 = 2 * rise;
         run_x2 = 2 * run;
         err_term = 2 * rise - run;
         line_on = 1'b1;
      end else if (line_on) begin
         at_end = (maj_pos >= maj_end);
         case (fold_grp)
            GRP_POS_X: begin px = maj_pos;  py = min_pos;  end
            GRP_NEG_X: begin px = -maj_pos; py = min_pos;  end
            GRP_POS_Y: begin px = min_pos;  py = maj_pos;  end
            default:   begin px = min_pos;  py = -maj_pos; end
         endcase
         pt.x = px[CW-1:0];
         pt.y = py[CW-1:0];
         pt.last = at_end;
         made = 1'b1;
         if (at_end) begin
            line_on = 1'b0;
         end else begin
            maj_pos += 1;
            err_term += rise_x2;
            if (err_term > 0) begin
               err_term -= run_x2;
               min_pos += min_dir;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // request side monitor: every accepted beat runs the predictor
   // ------------------------------------------------------------------
   bit        req_made;
   point_type req_point;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         raster_step(req_command, req_start_x, req_start_y, req_end_x, req_end_y,
                     req_made, req_point);
         // a typed row overrides the predictor but the state still advances
         if (beat_kind == CHK_TYPED) begin
            pending_points.push_back(beat_point);
         end else if (beat_kind == CHK_PREDICT && req_made) begin
            pending_points.push_back(req_point);
         end
      end
   end

   // ------------------------------------------------------------------
   // result side: random back-pressure, redrawn after every accepted beat
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         stall_left = quiet ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker, oldest expectation first
   point_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                     rsp_point_x, rsp_point_y, rsp_last_point);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_x !== want.x) begin
               $display("%0t: point_x expected %0d got %0d", $time, want.x, rsp_point_x);
               error_count++;
            end
            if (rsp_point_y !== want.y) begin
               $display("%0t: point_y expected %0d got %0d", $time, want.y, rsp_point_y);
               error_count++;
            end
            if (rsp_last_point !== want.last) begin
               $display("%0t: last_point expected %0b got %0b", $time,
                        want.last, rsp_last_point);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long with no beat on either side ends the run
   int stuck_cycles = 0;

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // request driver: optional idle gap, then hold the beat until taken
   // ------------------------------------------------------------------
   task automatic send_beat(input logic cmd,
                            input logic signed [CW-1:0] sx, sy, ex, ey,
                            input chk_kind_type kind, input point_type pt);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      // valid only drops when there really is a gap
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      beat_kind   <= kind;
      beat_point  <= pt;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic add_row(input logic cmd, input int sx, sy, ex, ey,
                          input chk_kind_type kind, input int px = 0, py = 0,
                          input logic last = 1'b0);
      stim_row_type r;
      r.cmd = cmd;
      r.sx = sx[CW-1:0];
      r.sy = sy[CW-1:0];
      r.ex = ex[CW-1:0];
      r.ey = ey[CW-1:0];
      r.kind = kind;
      r.pt.x = px[CW-1:0];
      r.pt.y = py[CW-1:0];
      r.pt.last = last;
      plan.push_back(r);
   endtask

   // random junk on the endpoint ports of a step beat
   task automatic send_step();
      send_beat(CMD_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                CHK_PREDICT, '0);
   endtask

   // a well-formed line: load, then steps up to (or past, or short of) its end
   task automatic random_line();
      int len, side, dx, dy, sx, sy, ex, ey, steps;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      side = $urandom_range(0, len);
      if ($urandom_range(0, 1)) begin
         dx = len; dy = side;
      end else begin
         dx = side; dy = len;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      sx = int'($urandom_range(0, 32767)) + COORD_MIN;
      sy = int'($urandom_range(0, 32767)) + COORD_MIN;
      ex = sx + dx;
      ey = sy + dy;
      // keep the end on the grid by mirroring the offset
      if (ex > COORD_MAX || ex < COORD_MIN) ex = sx - dx;
      if (ey > COORD_MAX || ey < COORD_MIN) ey = sy - dy;
      send_beat(CMD_LOAD, sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0], CHK_PREDICT, '0);
      steps = len + 1;
      if ($urandom_range(0, 7) == 0) begin
         steps = $urandom_range(1, len + 1);          // cut short, next load replaces it
      end else if ($urandom_range(0, 3) == 0) begin
         steps += $urandom_range(1, 2);               // steps into an idle stepper
      end
      items_sent += 1 + steps;
      repeat (steps) send_step();
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      // step with no line, then a zero-length line and a step past its end
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NOTHING);
      add_row(CMD_LOAD, 0, 0, 0, 0, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, 0, 0, 1'b1);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NOTHING);
      // full-range diagonal, +x wins the tie with +y
      add_row(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, COORD_MIN, COORD_MIN, 1'b0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, COORD_MIN + 1, COORD_MIN + 1, 1'b0);
      // full-range -x, replacing the line in progress
      add_row(CMD_LOAD, COORD_MAX, 5, COORD_MIN, 5, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, COORD_MAX, 5, 1'b0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, COORD_MAX - 1, 5, 1'b0);
      // full-range +y
      add_row(CMD_LOAD, 0, COORD_MIN, 0, COORD_MAX, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, 0, COORD_MIN, 1'b0);
      // full-range -y
      add_row(CMD_LOAD, 7, COORD_MAX, 7, COORD_MIN, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, 7, COORD_MAX, 1'b0);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, 7, COORD_MAX - 1, 1'b0);
      // anti-diagonal across the grid, +x wins the tie with -y
      add_row(CMD_LOAD, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT);
      // short +x/-y tie run to the end and one step past it
      add_row(CMD_LOAD, 0, 0, 3, -3, CHK_PREDICT);
      repeat (4) add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_NOTHING);
      // -x beats +y on a tie
      add_row(CMD_LOAD, 0, 0, -2, 2, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_PREDICT);
      // load mid-line replaces it with a single point
      add_row(CMD_LOAD, 1, 1, 1, 1, CHK_PREDICT);
      add_row(CMD_STEP, 0, 0, 0, 0, CHK_TYPED, 1, 1, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_beat(plan[i].cmd, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
                   plan[i].kind, plan[i].pt);
      end
      items_sent = plan.size();

      // random part: mostly whole lines, some raw noise beats
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 29) == 0) quiet <= ~quiet;
         if ($urandom_range(0, 9) < 8) begin
            random_line();
         end else begin
            send_beat(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                      CW'($urandom), CW'($urandom), CHK_PREDICT, '0);
            items_sent++;
         end
      end

      // drain: everything owed must come back, then a short quiet tail
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (pending_points.size() != 0) begin
         $display("%0t: expected %0d more points, got none", $time,
                  pending_points.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_setup.sv
rtl/bls_stepper.sv
rtl/bresenham_line_stepper_top.sv
rtl/bls_checker.sv
sim/tb_top.sv
